@@ rtl/core/owbm_pkg.sv @@
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types, timing constants and slot helpers for the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  // Command codes as they arrive on the input stream
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_RESET = 3'd1,
    CMD_WBYTE = 3'd2,
    CMD_RBYTE = 3'd3,
    CMD_WBIT  = 3'd4,
    CMD_RBIT  = 3'd5
  } owbm_cmd_e;

  // Bus phase of the slot engine
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RESET = 2'd1,
    PH_WRITE = 2'd2,
    PH_READ  = 2'd3
  } owbm_phase_e;

  // Register word indexes on the configuration port
  localparam logic REG_TPU = 1'b0;

  localparam int unsigned US_W     = 10;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Slot timing in microseconds
  localparam logic [US_W-1:0] RST_LOW    = US_W'(500);
  localparam logic [US_W-1:0] RST_SAMPLE = US_W'(500 + 60);
  localparam logic [US_W-1:0] RST_TOTAL  = US_W'(500 + 60 + 420);
  localparam logic [US_W-1:0] W1_LOW     = US_W'(10);
  localparam logic [US_W-1:0] W1_TOTAL   = US_W'(10 + 55);
  localparam logic [US_W-1:0] W0_LOW     = US_W'(65);
  localparam logic [US_W-1:0] W0_TOTAL   = US_W'(65 + 5);
  localparam logic [US_W-1:0] RD_LOW     = US_W'(3);
  localparam logic [US_W-1:0] RD_SAMPLE  = US_W'(3 + 10);
  localparam logic [US_W-1:0] RD_TOTAL   = US_W'(3 + 10 + 57);

  // One classified tick, front to back
  typedef struct packed {
    owbm_cmd_e  cmd;
    logic [7:0] data;
    logic       level;
  } owbm_item_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic not_empty;
  } owbm_qstat_t;

  // Back-end status for observation
  typedef struct packed {
    owbm_phase_e phase;
    logic        pop;
  } owbm_bstat_t;

  // Length of the low part of the current slot
  function automatic logic [US_W-1:0] slot_low(owbm_phase_e ph, logic bit0);
    logic [US_W-1:0] v;
    unique case (ph)
      PH_RESET: v = RST_LOW;
      PH_WRITE: v = bit0 ? W1_LOW : W0_LOW;
      default:  v = RD_LOW;
    endcase
    return v;
  endfunction

  // Total length of the current slot
  function automatic logic [US_W-1:0] slot_total(owbm_phase_e ph, logic bit0);
    logic [US_W-1:0] v;
    unique case (ph)
      PH_RESET: v = RST_TOTAL;
      PH_WRITE: v = bit0 ? W1_TOTAL : W0_TOTAL;
      default:  v = RD_TOTAL;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/owbm_front.sv @@
// ----------------------------------------------------------------------------
// owbm_front
// Input side: takes transactions from the stream and classifies the command.
// ----------------------------------------------------------------------------
module owbm_front
  import owbm_pkg::*;
(
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [8:0]  in_tdata,   // [7:0] data_in, [8] bus_level
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  input  owbm_qstat_t qstat,
  output logic        push,
  output owbm_item_t  item
);

  owbm_cmd_e cmd_cls;

  // Codes outside the command set behave as no command
  always_comb begin
    unique case (in_tuser)
      CMD_RESET, CMD_WBYTE, CMD_RBYTE, CMD_WBIT, CMD_RBIT: begin
        cmd_cls = owbm_cmd_e'(in_tuser);
      end
      default: begin
        cmd_cls = CMD_NONE;
      end
    endcase
  end

  assign in_tready  = rst_n & ~qstat.full;
  assign push       = in_tvalid & in_tready;
  assign item.cmd   = cmd_cls;
  assign item.data  = in_tdata[7:0];
  assign item.level = in_tdata[8];

endmodule

@@ rtl/core/owbm_fifo.sv @@
// ----------------------------------------------------------------------------
// owbm_fifo
// Short queue between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module owbm_fifo
  import owbm_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  owbm_item_t  wr_item,
  input  logic        pop,
  output owbm_item_t  rd_item,
  output owbm_qstat_t qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  owbm_item_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign do_push = push & (cnt_r != CNT_W'(DEPTH));
  assign do_pop  = pop & (cnt_r != '0);

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    priority if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push)     cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_item;
  end

  assign rd_item         = mem[rd_ptr_r];
  assign qstat.full      = (cnt_r == CNT_W'(DEPTH));
  assign qstat.not_empty = (cnt_r != '0);

endmodule

@@ rtl/core/owbm_back.sv @@
// ----------------------------------------------------------------------------
// owbm_back
// Slot engine: runs one tick per queued transaction and registers the result.
// ----------------------------------------------------------------------------
module owbm_back
  import owbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  tpu,
  input  owbm_qstat_t qstat,
  input  owbm_item_t  item,
  output logic        pop,
  output owbm_bstat_t bstat,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);

  owbm_phase_e     phase_r, phase_nxt;
  logic [7:0]      presc_r, presc_nxt;
  logic [US_W-1:0] us_r, us_nxt;
  logic [3:0]      bits_r, bits_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic            byte_r, byte_nxt;
  logic            seen_r, seen_nxt;
  logic            out_vld_r;
  logic [15:0]     out_data_r, res_data;

  logic [8:0]      pre, tpu_eff;
  logic [US_W-1:0] us_inc;
  logic [3:0]      bits_dec;
  logic            done, pres, rej, drive, busy;
  logic [7:0]      rdata;

  // Take a tick when the output register is free or being drained
  assign pop = qstat.not_empty & (~out_vld_r | out_tready);

  assign tpu_eff  = (tpu == 8'd0) ? 9'd1 : {1'b0, tpu};
  assign pre      = {1'b0, presc_r} + 9'd1;
  assign us_inc   = us_r + 1'b1;
  assign bits_dec = (bits_r != 4'd0) ? bits_r - 4'd1 : 4'd0;

  // Next state and result of one tick
  always_comb begin
    phase_nxt = phase_r;
    presc_nxt = presc_r;
    us_nxt    = us_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    byte_nxt  = byte_r;
    seen_nxt  = seen_r;
    done      = 1'b0;
    pres      = 1'b0;
    rej       = 1'b0;
    rdata     = 8'd0;
    if (pop) begin
      if (phase_r == PH_IDLE) begin
        // Start of a command: this tick is microsecond zero of the first slot
        if (item.cmd != CMD_NONE) begin
          presc_nxt = '0;
          us_nxt    = '0;
          byte_nxt  = (item.cmd == CMD_RBYTE);
          unique case (item.cmd)
            CMD_RESET: begin
              phase_nxt = PH_RESET; bits_nxt = 4'd1; shift_nxt = '0; seen_nxt = 1'b0;
            end
            CMD_WBYTE: begin
              phase_nxt = PH_WRITE; bits_nxt = 4'd8; shift_nxt = item.data;
            end
            CMD_RBYTE: begin
              phase_nxt = PH_READ; bits_nxt = 4'd8; shift_nxt = '0;
            end
            CMD_WBIT: begin
              phase_nxt = PH_WRITE; bits_nxt = 4'd1; shift_nxt = {7'd0, item.data[0]};
            end
            CMD_RBIT: begin
              phase_nxt = PH_READ; bits_nxt = 4'd1; shift_nxt = '0;
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end else begin
        rej = (item.cmd != CMD_NONE);
        if (pre >= tpu_eff) begin
          // Microsecond boundary
          presc_nxt = '0;
          us_nxt    = us_inc;
          if (phase_r == PH_RESET && us_inc == RST_SAMPLE) seen_nxt = ~item.level;
          if (phase_r == PH_READ && us_inc == RD_SAMPLE)
            shift_nxt = byte_r ? {item.level, shift_r[7:1]} : {7'd0, item.level};
          if (us_inc >= slot_total(phase_r, shift_r[0])) begin
            // Slot end, also first tick of the next slot
            if (phase_r == PH_WRITE) shift_nxt = {1'b0, shift_r[7:1]};
            bits_nxt = bits_dec;
            us_nxt   = '0;
            if (bits_dec == 4'd0) begin
              done      = 1'b1;
              pres      = (phase_r == PH_RESET) & seen_nxt;
              rdata     = (phase_r == PH_READ) ? shift_nxt : 8'd0;
              phase_nxt = PH_IDLE;
            end
          end
        end else begin
          presc_nxt = pre[7:0];
        end
      end
    end
    busy  = (phase_nxt != PH_IDLE);
    drive = busy & (us_nxt < slot_low(phase_nxt, shift_nxt[0]));
    res_data = {3'd0, rej, rdata, pres, done, busy, drive};
  end

  // Engine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      presc_r <= '0;
      us_r    <= '0;
      bits_r  <= '0;
      shift_r <= '0;
      byte_r  <= 1'b0;
      seen_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      presc_r <= presc_nxt;
      us_r    <= us_nxt;
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
      byte_r  <= byte_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pop) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= res_data;
  end

  assign out_tvalid  = out_vld_r;
  assign out_tdata   = out_data_r;
  assign bstat.phase = phase_r;
  assign bstat.pop   = pop;

endmodule

@@ rtl/core/one_wire_bus_master_top.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master_top
// 1-Wire bus master: reset/presence, bit and byte write/read slots.
// ----------------------------------------------------------------------------
// Each input transaction is one tick of bus time and yields exactly one output
// transaction with the drive level and status after that tick. While the
// output is not stalled, a transaction is taken every clock cycle: the front
// decodes it into a short queue, the slot engine consumes one queued tick per
// cycle into an output register, so throughput is one per cycle.
// Backpressure on the output stalls the engine; the queue then fills and
// in_tready drops. ticks_per_microsecond (byte address 0) sets how many ticks
// make one microsecond; write it only while no operation is running.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top
  import owbm_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [7:0] data_in, [8] bus_level
  input  logic [2:0]  in_tuser,    // [2:0] cmd
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [0] drive_low, [1] busy_res, [2] op_done,
                                   // [3] presence, [11:4] read_data, [12] cmd_rejected
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        tpu_sel;
  logic [7:0]  tpu_val_r;
  owbm_qstat_t qstat;
  owbm_item_t  wr_item, rd_item;
  owbm_bstat_t bstat;
  logic        push, pop, cfg_wr;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_val_r <= 8'd1;
    end else if (cfg_wr && cfg_paddr[2] == REG_TPU) begin
      tpu_val_r <= cfg_pwdata[7:0];
    end
  end

  assign tpu_sel    = (cfg_paddr[2] == REG_TPU);
  assign cfg_prdata = tpu_sel ? {24'd0, tpu_val_r} : 32'd0;

  owbm_front u_front (
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata[8:0]),
    .in_tuser  (in_tuser),
    .qstat     (qstat),
    .push      (push),
    .item      (wr_item)
  );

  owbm_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .qstat   (qstat)
  );

  owbm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tpu        (tpu_val_r),
    .qstat      (qstat),
    .item       (rd_item),
    .pop        (pop),
    .bstat      (bstat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A valid command taken while idle starts an operation
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && bstat.phase == PH_IDLE && rd_item.cmd != CMD_NONE)
      |=> (bstat.phase != PH_IDLE))
    else $error("command did not start an operation");

  // A valid command taken while busy is flagged as rejected
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && bstat.phase != PH_IDLE && rd_item.cmd != CMD_NONE)
      |=> (out_tvalid && out_tdata[12]))
    else $error("busy command not rejected");

  // Engine state only moves on a consumed tick
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> $stable(bstat.phase))
    else $error("phase changed without a tick");

endmodule
